// ===== rtl/core/idw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idw_pkg
// Shared types and codes for the display write master: the request and
// response words and the sequencer phase codes.
// ----------------------------------------------------------------------------
package idw_pkg;

   localparam int unsigned AddrWidth = 7;

   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_CMD   = 2'd1;
   localparam logic [1:0] OP_DATA  = 2'd2;
   localparam logic [1:0] OP_PROBE = 2'd3;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_START = 3'd1;
   localparam logic [2:0] PH_BIT   = 3'd2;
   localparam logic [2:0] PH_ACK   = 3'd3;
   localparam logic [2:0] PH_WAIT  = 3'd4;
   localparam logic [2:0] PH_STOP  = 3'd5;

   localparam logic [1:0] ST_ADDR = 2'd0;
   localparam logic [1:0] ST_CTRL = 2'd1;
   localparam logic [1:0] ST_PAY  = 2'd2;

   localparam logic [7:0] CTRL_CMD  = 8'h00;
   localparam logic [7:0] CTRL_DATA = 8'h40;

   localparam logic [AddrWidth-1:0] ADDR_RESET = 7'd60;

   typedef struct packed {
      logic [1:0] operation;
      logic       byte_valid;
      logic [7:0] byte_value;
      logic       byte_last;
      logic       sda_in;
   } req_word_type;

   typedef struct packed {
      logic scl_out;
      logic sda_out;
      logic byte_taken;
      logic busy_res;
      logic done_res;
      logic all_acked;
   } rsp_word_type;

endpackage

// ===== rtl/core/idw_req_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idw_req_stage
// Input register for request words. It holds one word until the engine
// consumes it and stalls the sender while it is full and not draining.
// ----------------------------------------------------------------------------
module idw_req_stage
   import idw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   input  logic         consume,
   output logic         word_valid,
   output req_word_type word
);

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;
   logic         accept;

   assign req_stall  = valid_ff & ~consume;
   assign accept     = req_valid & ~req_stall;
   assign word_valid = valid_ff;
   assign word       = word_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= req_word;
      end
   end

endmodule

// ===== rtl/core/idw_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idw_engine
// Bus sequencer state and its next-state logic. Each consumed word is one
// half-period tick of the bus and yields one response word.
// ----------------------------------------------------------------------------
module idw_engine
   import idw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  req_word_type         word,
   input  logic                 csr_wr_en,
   input  logic [AddrWidth-1:0] csr_wr_data,
   output rsp_word_type         result
);

   logic [AddrWidth-1:0] addr_ff;
   logic [2:0]           phase_ff,  phase_in;
   logic [1:0]           tick_ff,   tick_in;
   logic [3:0]           count_ff,  count_in;
   logic [7:0]           shift_ff,  shift_in;
   logic [1:0]           stage_ff,  stage_in;
   logic [1:0]           kind_ff,   kind_in;
   logic                 ack_ff,    ack_in;
   logic                 last_ff,   last_in;
   logic [1:0]           lines_ff,  lines_in;
   logic                 scl;
   logic                 sda;
   logic                 taken;
   logic                 done;
   logic                 acked;
   logic [3:0]           count_inc;

   assign count_inc = count_ff + 4'd1;

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      count_in = count_ff;
      shift_in = shift_ff;
      stage_in = stage_ff;
      kind_in  = kind_ff;
      ack_in   = ack_ff;
      last_in  = last_ff;
      scl      = lines_ff[1];
      sda      = lines_ff[0];
      taken    = 1'b0;
      done     = 1'b0;
      acked    = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            scl = 1'b1;
            sda = 1'b1;
            if (word.operation != OP_NONE) begin
               kind_in  = word.operation;
               ack_in   = 1'b1;
               stage_in = ST_ADDR;
               last_in  = 1'b0;
               count_in = 4'd0;
               phase_in = PH_START;
               tick_in  = 2'd1;
            end
         end
         PH_START: begin
            if (tick_ff == 2'd1) begin
               sda     = 1'b0;
               tick_in = 2'd2;
            end else begin
               scl      = 1'b0;
               shift_in = {addr_ff, 1'b0};
               phase_in = PH_BIT;
               tick_in  = 2'd0;
               count_in = 4'd0;
            end
         end
         PH_BIT: begin
            case (tick_ff)
               2'd0: begin
                  scl     = 1'b0;
                  sda     = shift_ff[7];
                  tick_in = 2'd1;
               end
               2'd1: begin
                  scl     = 1'b1;
                  tick_in = 2'd2;
               end
               default: begin
                  scl      = 1'b0;
                  shift_in = {shift_ff[6:0], 1'b0};
                  count_in = count_inc;
                  tick_in  = 2'd0;
                  if (count_inc >= 4'd8) begin
                     count_in = 4'd0;
                     phase_in = PH_ACK;
                  end
               end
            endcase
         end
         PH_ACK: begin
            case (tick_ff)
               2'd0: begin
                  scl     = 1'b0;
                  sda     = 1'b1;
                  tick_in = 2'd1;
               end
               2'd1: begin
                  scl     = 1'b1;
                  tick_in = 2'd2;
                  if (word.sda_in) begin
                     ack_in = 1'b0;
                  end
               end
               default: begin
                  scl     = 1'b0;
                  tick_in = 2'd0;
                  if (stage_ff == ST_ADDR) begin
                     if (kind_ff == OP_PROBE) begin
                        phase_in = PH_STOP;
                     end else begin
                        shift_in = (kind_ff == OP_DATA) ? CTRL_DATA : CTRL_CMD;
                        stage_in = ST_CTRL;
                        phase_in = PH_BIT;
                     end
                  end else if (stage_ff == ST_PAY && last_ff) begin
                     phase_in = PH_STOP;
                  end else begin
                     stage_in = ST_PAY;
                     phase_in = PH_WAIT;
                  end
               end
            endcase
         end
         PH_WAIT: begin
            scl = 1'b0;
            if (word.byte_valid) begin
               taken    = 1'b1;
               shift_in = word.byte_value;
               last_in  = word.byte_last;
               sda      = word.byte_value[7];
               phase_in = PH_BIT;
               tick_in  = 2'd1;
            end
         end
         PH_STOP: begin
            case (tick_ff)
               2'd0: begin
                  scl     = 1'b0;
                  sda     = 1'b0;
                  tick_in = 2'd1;
               end
               2'd1: begin
                  scl     = 1'b1;
                  tick_in = 2'd2;
               end
               default: begin
                  sda      = 1'b1;
                  done     = 1'b1;
                  acked    = ack_ff;
                  phase_in = PH_IDLE;
                  tick_in  = 2'd0;
               end
            endcase
         end
         default: begin
            scl      = 1'b1;
            sda      = 1'b1;
            phase_in = PH_IDLE;
            tick_in  = 2'd0;
         end
      endcase
      lines_in = {scl, sda};
   end

   assign result.scl_out    = scl;
   assign result.sda_out    = sda;
   assign result.byte_taken = taken;
   assign result.busy_res   = (phase_in != PH_IDLE);
   assign result.done_res   = done;
   assign result.all_acked  = acked;

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= ADDR_RESET;
      end else if (csr_wr_en) begin
         addr_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= 2'd0;
         count_ff <= 4'd0;
         shift_ff <= 8'd0;
         stage_ff <= ST_ADDR;
         kind_ff  <= OP_NONE;
         ack_ff   <= 1'b1;
         last_ff  <= 1'b0;
         lines_ff <= 2'b11;
      end else if (fire) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         count_ff <= count_in;
         shift_ff <= shift_in;
         stage_ff <= stage_in;
         kind_ff  <= kind_in;
         ack_ff   <= ack_in;
         last_ff  <= last_in;
         lines_ff <= lines_in;
      end
   end

   a_tick_range: assert property (@(posedge clock) disable iff (reset)
      tick_ff != 2'd3)
      else $error("Tick counter left its range.");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < 4'd8)
      else $error("Bit counter passed eight.");

   a_done_from_stop: assert property (@(posedge clock) disable iff (reset)
      fire && done |=> phase_ff == PH_IDLE && $past(phase_ff) == PH_STOP)
      else $error("Completion outside the STOP sequence.");

   a_taken_in_wait: assert property (@(posedge clock) disable iff (reset)
      fire && taken |=> phase_ff == PH_BIT && tick_ff == 2'd1 && $past(phase_ff) == PH_WAIT)
      else $error("Payload byte taken outside the payload wait.");

endmodule

// ===== rtl/core/idw_rsp_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idw_rsp_stage
// Output register for response words. It can load a new word in the same
// cycle that the held word is taken.
// ----------------------------------------------------------------------------
module idw_rsp_stage
   import idw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_word_type load_word,
   output logic         can_load,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   assign can_load  = ~valid_ff | ~rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (~rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= load_word;
      end
   end

endmodule

// ===== rtl/core/i2c_display_write_master.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_display_write_master
// Write-only I2C master for a display controller, stepped one bus half-period
// tick per request word.
//
//   Port group   Direction   Handshake           Contents
//   req_*        in          req_valid/stall     operation, payload byte, SDA
//   rsp_*        out         rsp_valid/stall     SCL/SDA drive and status
//   csr_*        in          csr_wr_en           seven-bit slave address
//
// One request word is accepted per cycle while req_stall is low. A word passes
// through the input register and then the output register, from which its
// response word is offered. Reset is synchronous and returns the sequencer
// to idle with both lines released. A stalled response stalls the request
// side only once both registers are full.
// ----------------------------------------------------------------------------
module i2c_display_write_master
   import idw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_operation,
   input  logic                 req_byte_valid,
   input  logic [7:0]           req_byte_value,
   input  logic                 req_byte_last,
   input  logic                 req_sda_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_scl_out,
   output logic                 rsp_sda_out,
   output logic                 rsp_byte_taken,
   output logic                 rsp_busy_res,
   output logic                 rsp_done_res,
   output logic                 rsp_all_acked,
   input  logic                 csr_wr_en,
   input  logic [AddrWidth-1:0] csr_wr_data
);

   req_word_type req_word;
   req_word_type held_word;
   rsp_word_type step_word;
   rsp_word_type out_word;
   logic         held_valid;
   logic         can_load;
   logic         fire;

   assign req_word.operation  = req_operation;
   assign req_word.byte_valid = req_byte_valid;
   assign req_word.byte_value = req_byte_value;
   assign req_word.byte_last  = req_byte_last;
   assign req_word.sda_in     = req_sda_in;

   assign fire = held_valid & can_load;

   idw_req_stage u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .consume    (fire),
      .word_valid (held_valid),
      .word       (held_word)
   );

   idw_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .word        (held_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .result      (step_word)
   );

   idw_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .load_word (step_word),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (out_word)
   );

   assign rsp_scl_out    = out_word.scl_out;
   assign rsp_sda_out    = out_word.sda_out;
   assign rsp_byte_taken = out_word.byte_taken;
   assign rsp_busy_res   = out_word.busy_res;
   assign rsp_done_res   = out_word.done_res;
   assign rsp_all_acked  = out_word.all_acked;

endmodule
